FILE: design/free_index_ring_allocator_assert.svh
// Assertion macros for the free index ring allocator.
// Included by the modules that check themselves; depends on nothing else.
`ifndef FREE_INDEX_RING_ALLOCATOR_ASSERT_SVH
`define FREE_INDEX_RING_ALLOCATOR_ASSERT_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside reset.
`define FIRA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("fira: assertion failed");
// Check a property on every rising edge, reset included.
`define FIRA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fira: assertion failed");
`else
`define FIRA_ASSERT(lbl, clk, rst, prop)
`define FIRA_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: design/fira_pkg.sv
// Shared types and constants of the free index ring allocator.
// Used by the store, the sequencer and the top level; depends on nothing.
package fira_pkg;

  localparam int WORD_W    = 16;
  localparam int TOP_OUT_W = 10;
  localparam int NUM_SLOTS = 3;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_CELL    = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  // Port enables of the pool memory
  typedef struct packed {
    logic we;
    logic re;
  } fira_mem_ctl_t;

endpackage

FILE: design/fira_store.sv
// Pool memory: one write port, one read port with registered read data.
// Depends on fira_pkg.
module fira_store #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic                        clk,
  input  fira_pkg::fira_mem_ctl_t     ctl,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [fira_pkg::WORD_W-1:0] wdata,
  input  logic [ADDR_W-1:0]           raddr,
  output logic [fira_pkg::WORD_W-1:0] rdata
);
  import fira_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[waddr] <= wdata;
    end
    if (ctl.re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: design/fira_ctrl.sv
// Sequencer of the free index ring allocator: fill sweep, top pointer,
// release slots and result registers. Depends on fira_pkg and the assert macros.
`include "free_index_ring_allocator_assert.svh"

module fira_ctrl #(
  parameter int POOL_DEPTH      = 1024,
  parameter int PTR_W           = 10,
  parameter int CELL_INDEX_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [1:0]                     opcode,
  input  logic [fira_pkg::WORD_W-1:0]    release_index,
  input  logic [fira_pkg::WORD_W-1:0]    cell_word,
  input  logic [fira_pkg::WORD_W-1:0]    owned_first,
  input  logic [fira_pkg::WORD_W-1:0]    owned_second,
  output logic                           busy,
  output logic                           done,
  output logic [fira_pkg::WORD_W-1:0]    granted_index,
  output logic [fira_pkg::TOP_OUT_W-1:0] top_out,
  output logic [fira_pkg::WORD_W-1:0]    cell_word_out,
  output logic [fira_pkg::WORD_W-1:0]    owned_first_out,
  output logic [fira_pkg::WORD_W-1:0]    owned_second_out,
  output fira_pkg::fira_mem_ctl_t        mem_ctl,
  output logic [PTR_W-1:0]               waddr,
  output logic [fira_pkg::WORD_W-1:0]    wdata,
  output logic [PTR_W-1:0]               raddr,
  input  logic [fira_pkg::WORD_W-1:0]    rdata
);
  import fira_pkg::*;

  localparam logic [1:0] ST_INIT  = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_ALLOC = 2'd2;
  localparam logic [1:0] ST_WRITE = 2'd3;

  localparam logic [PTR_W-1:0] TOP_LAST  = PTR_W'(POOL_DEPTH - 1);
  localparam logic [16:0]      CELL_MASK = (17'd1 << CELL_INDEX_BITS) - 17'd1;

  logic [1:0]        state;
  logic [PTR_W-1:0]  init_addr;
  logic [PTR_W-1:0]  top;
  logic [1:0]        slot;
  logic [2:0]        slot_valid;
  logic [WORD_W-1:0] slot_data [NUM_SLOTS];
  logic              alloc_hit;
  logic [WORD_W-1:0] cell_keep;
  logic [WORD_W-1:0] own1_keep;
  logic [WORD_W-1:0] own2_keep;

  logic              accept;
  logic              alloc_go;
  logic [PTR_W-1:0]  top_inc;
  logic [PTR_W-1:0]  top_dec;
  logic [PTR_W-1:0]  top_new;
  logic [31:0]       top_new_wide;
  logic [WORD_W-1:0] cell_idx;
  logic              slot_write;
  logic              slot_last;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign alloc_go = accept && (opcode == OP_ALLOC) && (top != '0);

  // Ring arithmetic on the top pointer; the depth need not be a power of two
  assign top_inc = (top == TOP_LAST) ? '0 : top + PTR_W'(1);
  assign top_dec = (top == '0) ? TOP_LAST : top - PTR_W'(1);

  assign cell_idx   = cell_word & CELL_MASK[WORD_W-1:0];
  assign slot_write = (state == ST_WRITE) && slot_valid[slot];
  assign slot_last  = (slot == 2'd2) ||
                      ((slot == 2'd1) && !slot_valid[2]) ||
                      ((slot == 2'd0) && (slot_valid[2:1] == 2'b00));

  assign top_new      = slot_write ? top_dec : top;
  assign top_new_wide = 32'(top_new);

  // Memory ports: sweep during fill, push during slot writes, read top in idle
  assign mem_ctl.we = (state == ST_INIT) || slot_write;
  assign mem_ctl.re = (state == ST_IDLE);
  assign waddr      = (state == ST_INIT) ? init_addr : top_dec;
  assign wdata      = (state == ST_INIT) ? WORD_W'(init_addr) : slot_data[slot];
  assign raddr      = top;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_INIT;
      init_addr <= '0;
      top       <= PTR_W'(1);
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        ST_INIT: begin
          init_addr <= init_addr + PTR_W'(1);
          if (init_addr == TOP_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            cell_keep <= cell_word;
            own1_keep <= owned_first;
            own2_keep <= owned_second;
            slot      <= 2'd0;
            unique case (opcode)
              OP_ALLOC: begin
                alloc_hit <= (top != '0);
                if (top != '0) begin
                  top <= top_inc;
                end
                state <= ST_ALLOC;
              end
              OP_RELEASE: begin
                slot_data[0] <= release_index;
                slot_valid   <= 3'b001;
                state        <= ST_WRITE;
              end
              OP_CELL: begin
                if (cell_idx != '0) begin
                  slot_data[0] <= cell_idx;
                  slot_data[1] <= owned_first;
                  slot_data[2] <= owned_second;
                  slot_valid   <= {owned_second != '0, owned_first != '0, 1'b1};
                  cell_keep    <= '0;
                  own1_keep    <= '0;
                  own2_keep    <= '0;
                  state        <= ST_WRITE;
                end else begin
                  done             <= 1'b1;
                  granted_index    <= '0;
                  top_out          <= top_new_wide[TOP_OUT_W-1:0];
                  cell_word_out    <= cell_word;
                  owned_first_out  <= owned_first;
                  owned_second_out <= owned_second;
                end
              end
              default: begin
                done             <= 1'b1;
                granted_index    <= '0;
                top_out          <= top_new_wide[TOP_OUT_W-1:0];
                cell_word_out    <= cell_word;
                owned_first_out  <= owned_first;
                owned_second_out <= owned_second;
              end
            endcase
          end
        end
        ST_ALLOC: begin
          done             <= 1'b1;
          granted_index    <= alloc_hit ? rdata : '0;
          top_out          <= top_new_wide[TOP_OUT_W-1:0];
          cell_word_out    <= cell_keep;
          owned_first_out  <= own1_keep;
          owned_second_out <= own2_keep;
          state            <= ST_IDLE;
        end
        ST_WRITE: begin
          if (slot_write) begin
            top <= top_dec;
          end
          if (slot_last) begin
            done             <= 1'b1;
            granted_index    <= '0;
            top_out          <= top_new_wide[TOP_OUT_W-1:0];
            cell_word_out    <= cell_keep;
            owned_first_out  <= own1_keep;
            owned_second_out <= own2_keep;
            state            <= ST_IDLE;
          end else begin
            slot <= slot + 2'd1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `FIRA_ASSERT_ALWAYS(a_reset_to_fill, clk, rst |=> (state == ST_INIT))
  `FIRA_ASSERT(a_accept_progress, clk, rst, accept |=> (busy || done))
  `FIRA_ASSERT(a_write_not_idle, clk, rst, mem_ctl.we |-> (state != ST_IDLE))
  `FIRA_ASSERT(a_no_result_in_fill, clk, rst, (state == ST_INIT) |=> !done)
  `FIRA_ASSERT(a_alloc_advance, clk, rst, alloc_go |=> (top == $past(top_inc)))

endmodule

FILE: design/free_index_ring_allocator.sv
// Free index ring allocator. A request that leaves the pool alone strobes its
// result in the cycle after it is accepted; allocate goes through the pool read
// and ST_ALLOC, release through ST_WRITE, release-cell through ST_WRITE once per
// slot up to the last valid one (one pool write a cycle, set by the single write
// port). Requests are taken as soon as busy falls; no result stalls. Synchronous
// reset fills the pool one entry a cycle, busy high; entry i holds i, top reads 1.
module free_index_ring_allocator #(
  parameter int POOL_DEPTH      = 1024,
  parameter int CELL_INDEX_BITS = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     opcode,
  input  logic [fira_pkg::WORD_W-1:0]    release_index,
  input  logic [fira_pkg::WORD_W-1:0]    cell_word,
  input  logic [fira_pkg::WORD_W-1:0]    owned_first,
  input  logic [fira_pkg::WORD_W-1:0]    owned_second,
  output logic                           done,
  output logic [fira_pkg::WORD_W-1:0]    granted_index,
  output logic [fira_pkg::TOP_OUT_W-1:0] top_out,
  output logic [fira_pkg::WORD_W-1:0]    cell_word_out,
  output logic [fira_pkg::WORD_W-1:0]    owned_first_out,
  output logic [fira_pkg::WORD_W-1:0]    owned_second_out
);
  import fira_pkg::*;

  // Pointer width follows the pool depth exactly
  localparam int PTR_W = $clog2(POOL_DEPTH);

  fira_mem_ctl_t     mem_ctl;
  logic [PTR_W-1:0]  waddr;
  logic [PTR_W-1:0]  raddr;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] rdata;

  // Sequencer: holds the top pointer, queues up to three pushes per request
  // and drives the result registers. The pool is only read while idle and only
  // written while busy, so a read never meets a write to the same entry.
  fira_ctrl #(
    .POOL_DEPTH      (POOL_DEPTH),
    .PTR_W           (PTR_W),
    .CELL_INDEX_BITS (CELL_INDEX_BITS)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .opcode           (opcode),
    .release_index    (release_index),
    .cell_word        (cell_word),
    .owned_first      (owned_first),
    .owned_second     (owned_second),
    .busy             (busy),
    .done             (done),
    .granted_index    (granted_index),
    .top_out          (top_out),
    .cell_word_out    (cell_word_out),
    .owned_first_out  (owned_first_out),
    .owned_second_out (owned_second_out),
    .mem_ctl          (mem_ctl),
    .waddr            (waddr),
    .wdata            (wdata),
    .raddr            (raddr),
    .rdata            (rdata)
  );

  // Pool of free indices, with registered read data
  fira_store #(
    .DEPTH  (POOL_DEPTH),
    .ADDR_W (PTR_W)
  ) u_store (
    .clk   (clk),
    .ctl   (mem_ctl),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

endmodule
